### rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the canvas fill engine.
// No dependencies; every macro reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define CCSF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("canvas fill engine check failed");

// Next-cycle implication, off while reset is high.
`define CCSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("canvas fill engine check failed");

// Next-cycle implication that is also checked around reset.
`define CCSF_ASSERT_NEXT_NR(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("canvas fill engine check failed");

`endif

### rtl/ccsf_pkg.sv
// Shared types and constants of the character canvas fill engine.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ccsf_pkg;

   localparam int DEFAULT_MAX_ROWS = 64;
   localparam int DEFAULT_MAX_COLS = 64;

   // Width of the signed arithmetic used for rows and column spans.
   localparam int SPAN_W = 10;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 7;

   localparam logic [7:0] BLANK_CELL = 8'd46;
   localparam logic [6:0] ACTIVE_RESET = 7'd64;

   // Command kinds.
   localparam logic [2:0] KIND_RECT = 3'd0;
   localparam logic [2:0] KIND_UP = 3'd1;
   localparam logic [2:0] KIND_DOWN = 3'd2;
   localparam logic [2:0] KIND_DIAMOND = 3'd3;
   localparam logic [2:0] KIND_CLEAR = 3'd4;
   localparam logic [2:0] KIND_READ = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_ROWS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_COLS = 4'd1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_START,
      ST_ROW,
      ST_SPAN,
      ST_WIPE,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic row_step;
      logic paint;
      logic wipe_step;
      logic read;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic no_rows;
      logic row_hit;
      logic row_last;
      logic span_end;
      logic span_last;
      logic wipe_done;
      logic rsp_free;
   } dp_status_type;

endpackage

### rtl/ccsf_ctrl.sv
// Controller state machine of the canvas fill engine.
// Depends on ccsf_pkg; drives the datapath through command and status structs.
`timescale 1ns / 1ps

module ccsf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ccsf_pkg::dp_status_type status,
   output ccsf_pkg::dp_cmd_type   cmd
);

   ccsf_pkg::state_type state_ff;
   ccsf_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccsf_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ccsf_pkg::ST_INIT: begin
            cmd.wipe_step = 1'b1;
            if (status.wipe_done) begin
               state_in = ccsf_pkg::ST_IDLE;
            end
         end
         ccsf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ccsf_pkg::ST_START;
            end
         end
         ccsf_pkg::ST_START: begin
            case (status.kind)
               ccsf_pkg::KIND_RECT, ccsf_pkg::KIND_UP,
               ccsf_pkg::KIND_DOWN, ccsf_pkg::KIND_DIAMOND: begin
                  state_in = status.no_rows ? ccsf_pkg::ST_DONE : ccsf_pkg::ST_ROW;
               end
               ccsf_pkg::KIND_CLEAR: begin
                  state_in = ccsf_pkg::ST_WIPE;
               end
               ccsf_pkg::KIND_READ: begin
                  state_in = ccsf_pkg::ST_READ;
               end
               default: begin
                  state_in = ccsf_pkg::ST_DONE;
               end
            endcase
         end
         ccsf_pkg::ST_ROW: begin
            cmd.row_step = 1'b1;
            if (status.row_hit) begin
               state_in = ccsf_pkg::ST_SPAN;
            end else if (status.row_last) begin
               state_in = ccsf_pkg::ST_DONE;
            end
         end
         ccsf_pkg::ST_SPAN: begin
            cmd.paint = 1'b1;
            if (status.span_end) begin
               state_in = status.span_last ? ccsf_pkg::ST_DONE : ccsf_pkg::ST_ROW;
            end
         end
         ccsf_pkg::ST_WIPE: begin
            cmd.wipe_step = 1'b1;
            if (status.wipe_done) begin
               state_in = ccsf_pkg::ST_DONE;
            end
         end
         ccsf_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = ccsf_pkg::ST_DONE;
         end
         ccsf_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = ccsf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ccsf_pkg::ST_INIT;
         end
      endcase
   end

endmodule

### rtl/ccsf_datapath.sv
// Datapath of the canvas fill engine: command registers, span arithmetic,
// canvas memory, size registers and the result register. Depends on ccsf_pkg.
`timescale 1ns / 1ps

module ccsf_datapath #(
   parameter int MAX_ROWS = ccsf_pkg::DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = ccsf_pkg::DEFAULT_MAX_COLS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ccsf_pkg::dp_cmd_type                cmd,
   output ccsf_pkg::dp_status_type             status,
   input  logic [2:0]                          req_kind,
   input  logic signed [7:0]                   req_anchor_col,
   input  logic signed [7:0]                   req_anchor_row,
   input  logic [6:0]                          req_span_wide,
   input  logic [6:0]                          req_span_tall,
   input  logic [7:0]                          req_paint_char,
   input  logic [5:0]                          req_peek_row,
   input  logic [5:0]                          req_peek_col,
   input  logic                                csr_write,
   input  logic [ccsf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ccsf_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_cell_value,
   output logic                                rsp_cell_valid
);

   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AW = RW + CW;
   localparam int DEPTH = MAX_ROWS * (2 ** CW);
   localparam int SW = ccsf_pkg::SPAN_W;
   localparam logic [10:0] MAX_ROWS_W = 11'(MAX_ROWS);
   localparam logic [10:0] MAX_COLS_W = 11'(MAX_COLS);

   // Command registers.
   logic [2:0]         kind_ff;
   logic signed [7:0]  x_ff;
   logic signed [7:0]  y_ff;
   logic [6:0]         w_ff;
   logic [6:0]         h_ff;
   logic [7:0]         ch_ff;
   logic [5:0]         pr_ff;
   logic [5:0]         pc_ff;

   // Row walk and span registers.
   logic signed [7:0]  step_ff;
   logic [RW-1:0]      row_ff;
   logic [CW-1:0]      col_ff;
   logic [CW-1:0]      end_ff;
   logic               last_ff;

   logic [AW-1:0]      wipe_cnt_ff;
   logic [6:0]         active_rows_ff;
   logic [6:0]         active_cols_ff;
   logic [7:0]         rd_data_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_value_ff;
   logic               rsp_hit_ff;

   logic [7:0]         canvas_mem [DEPTH];

   logic [6:0]         rlim;
   logic [6:0]         clim;
   logic signed [SW-1:0] xs, ys, ss, hs, abs_s, half, rlim_s, clim_m1;
   logic signed [SW-1:0] row_v, c0, c1, c0c, c1c;
   logic               read_hit;

   // Limits beyond the store act as the store size.
   assign rlim = ({4'b0, active_rows_ff} > MAX_ROWS_W) ? MAX_ROWS_W[6:0] : active_rows_ff;
   assign clim = ({4'b0, active_cols_ff} > MAX_COLS_W) ? MAX_COLS_W[6:0] : active_cols_ff;

   always_comb begin
      xs = SW'(x_ff);
      ys = SW'(y_ff);
      ss = SW'(step_ff);
      hs = signed'({3'b0, h_ff});
      abs_s = (ss < 0) ? -ss : ss;
      half = hs - abs_s;
      rlim_s = signed'({3'b0, rlim});
      clim_m1 = signed'({3'b0, clim}) - SW'(1);
      row_v = ys + ss;
      c0 = xs;
      c1 = xs + signed'({3'b0, w_ff}) - SW'(1);
      case (kind_ff)
         ccsf_pkg::KIND_UP: begin
            c0 = xs - ss;
            c1 = xs + ss;
         end
         ccsf_pkg::KIND_DOWN: begin
            row_v = ys - ss;
            c0 = xs - ss;
            c1 = xs + ss;
         end
         ccsf_pkg::KIND_DIAMOND: begin
            c0 = xs - half;
            c1 = xs + half;
         end
         default: begin
         end
      endcase
      c0c = (c0 < 0) ? SW'(0) : c0;
      c1c = (c1 > clim_m1) ? clim_m1 : c1;
   end

   assign read_hit = ({1'b0, pr_ff} < rlim) && ({1'b0, pc_ff} < clim);

   always_comb begin
      status.kind = kind_ff;
      status.no_rows = (h_ff == 7'd0 && kind_ff != ccsf_pkg::KIND_DIAMOND)
                       || (kind_ff == ccsf_pkg::KIND_RECT && w_ff == 7'd0);
      status.row_hit = (row_v >= 0) && (row_v < rlim_s) && (c0c <= c1c);
      status.row_last = (kind_ff == ccsf_pkg::KIND_DIAMOND) ? (ss == hs)
                                                           : (ss == hs - SW'(1));
      status.span_end = (col_ff == end_ff);
      status.span_last = last_ff;
      status.wipe_done = (wipe_cnt_ff == AW'(DEPTH - 1));
      status.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         x_ff <= req_anchor_col;
         y_ff <= req_anchor_row;
         w_ff <= req_span_wide;
         h_ff <= req_span_tall;
         ch_ff <= req_paint_char;
         pr_ff <= req_peek_row;
         pc_ff <= req_peek_col;
         // A diamond walks its rows from -radius up to +radius.
         step_ff <= (req_kind == ccsf_pkg::KIND_DIAMOND) ? -signed'({1'b0, req_span_tall})
                                                        : 8'sd0;
      end else if (cmd.row_step) begin
         step_ff <= step_ff + 8'sd1;
         row_ff <= row_v[RW-1:0];
         col_ff <= c0c[CW-1:0];
         end_ff <= c1c[CW-1:0];
         last_ff <= status.row_last;
      end else if (cmd.paint) begin
         col_ff <= col_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wipe_cnt_ff <= '0;
         active_rows_ff <= ccsf_pkg::ACTIVE_RESET;
         active_cols_ff <= ccsf_pkg::ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.wipe_step) begin
            wipe_cnt_ff <= status.wipe_done ? '0 : wipe_cnt_ff + AW'(1);
         end
         if (csr_write && csr_index == ccsf_pkg::CSR_ACTIVE_ROWS) begin
            active_rows_ff <= csr_data;
         end
         if (csr_write && csr_index == ccsf_pkg::CSR_ACTIVE_COLS) begin
            active_cols_ff <= csr_data;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Canvas memory: one write port shared by wipe and paint, one read port.
   always_ff @(posedge clock) begin
      if (cmd.wipe_step) begin
         canvas_mem[wipe_cnt_ff] <= ccsf_pkg::BLANK_CELL;
      end else if (cmd.paint) begin
         canvas_mem[{row_ff, col_ff}] <= ch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= canvas_mem[{RW'(pr_ff), CW'(pc_ff)}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (kind_ff == ccsf_pkg::KIND_READ && read_hit) begin
            rsp_value_ff <= rd_data_ff;
            rsp_hit_ff <= 1'b1;
         end else begin
            rsp_value_ff <= 8'd0;
            rsp_hit_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_cell_valid = rsp_hit_ff;

endmodule

### rtl/character_canvas_shape_filler.sv
// Character canvas fill engine, top level. Items are taken one at a time.
// The engine is ready for the next item in the same cycle as the result of the last
// item is presented, which waits while the result before it is still untaken.
// Reset is synchronous; afterwards a clearing pass over the whole store of
// MAX_ROWS * 2**ceil(log2 MAX_COLS) cells runs with req_ready low, size writes taken.
`timescale 1ns / 1ps

// The engine keeps a canvas of 8-bit character cells in one memory. The
// controller walks each shape row by row; for every row the datapath works
// out the clipped column span combinationally, and then the span is painted at
// one cell per cycle. Rows that fall outside the active area, or whose span
// is empty after clipping, paint nothing.
//
// A clear item and the reset both sweep the whole memory writing '.', one
// cell per cycle. A read item fetches one cell through the registered read
// port; a read outside the active area returns zero with cell_valid low.
//
// Every item produces exactly one result. Results sit in an output register,
// so the engine finishes the next item's work while a result waits; it only
// stalls when a second result is ready before the first has been taken.
//
// The size registers are written through the csr_ port, which is always
// ready. Writes to indexes other than the two size registers are dropped.

module character_canvas_shape_filler #(
   parameter int MAX_ROWS = ccsf_pkg::DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = ccsf_pkg::DEFAULT_MAX_COLS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_kind,
   input  logic signed [7:0]                 req_anchor_col,
   input  logic signed [7:0]                 req_anchor_row,
   input  logic [6:0]                        req_span_wide,
   input  logic [6:0]                        req_span_tall,
   input  logic [7:0]                        req_paint_char,
   input  logic [5:0]                        req_peek_row,
   input  logic [5:0]                        req_peek_col,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_cell_value,
   output logic                              rsp_cell_valid,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ccsf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ccsf_pkg::CSR_DATA_W-1:0]   csr_data
);

   ccsf_pkg::dp_cmd_type    cmd;
   ccsf_pkg::dp_status_type status;

   // Configuration writes go straight into the size registers, so the port never stalls.
   assign csr_ready = 1'b1;

   ccsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ccsf_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_kind       (req_kind),
      .req_anchor_col (req_anchor_col),
      .req_anchor_row (req_anchor_row),
      .req_span_wide  (req_span_wide),
      .req_span_tall  (req_span_tall),
      .req_paint_char (req_paint_char),
      .req_peek_row   (req_peek_row),
      .req_peek_col   (req_peek_col),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cell_valid (rsp_cell_valid)
   );

endmodule

### rtl/ccsf_checker.sv
// Port-level checks of the canvas fill engine, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccsf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [7:0]                        rsp_cell_value,
   input logic                              rsp_cell_valid
);

   // After reset the clearing pass runs, so no item may be taken at once.
   `CCSF_ASSERT_NEXT_NR(a_reset_blocks_req, clock, reset, !req_ready)

   // One item at a time: an accepted item closes the input for the next cycle.
   `CCSF_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)

   // A result that is not a valid read carries a zero character.
   `CCSF_ASSERT_IMP(a_zero_when_invalid, clock, reset, rsp_valid && !rsp_cell_valid, rsp_cell_value == 8'd0)

   // A stalled result holds its payload.
   `CCSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cell_value) && $stable(rsp_cell_valid))

endmodule

bind character_canvas_shape_filler ccsf_checker u_checker (.*);

### dv/canvas_fill_checker.sv
`timescale 1ns / 1ps
// Checker for the character canvas fill engine: watches the item, result and size
// register channels, keeps its own canvas image and compares every result in order.
// Depends on ccsf_pkg for the command kinds, register indexes and the blank cell.

module canvas_fill_checker #(
   parameter int MAX_ROWS = ccsf_pkg::DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = ccsf_pkg::DEFAULT_MAX_COLS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [2:0]                       req_kind,
   input  logic signed [7:0]                req_anchor_col,
   input  logic signed [7:0]                req_anchor_row,
   input  logic [6:0]                       req_span_wide,
   input  logic [6:0]                       req_span_tall,
   input  logic [7:0]                       req_paint_char,
   input  logic [5:0]                       req_peek_row,
   input  logic [5:0]                       req_peek_col,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [7:0]                       rsp_cell_value,
   input  logic                             rsp_cell_valid,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [ccsf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ccsf_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               mismatch_count,
   output int                               pending_replies,
   output int                               replies_checked,
   output int                               active_reads
);

   import ccsf_pkg::*;

   typedef struct packed {
      logic [7:0] cell_value;
      logic       cell_valid;
   } cell_reply_type;

   logic [7:0]     canvas_image [MAX_ROWS*MAX_COLS];
   int             rows_setting;
   int             cols_setting;
   cell_reply_type expected_replies [$];
   int             errors_seen;
   int             checked_total;
   int             hits_total;
   cell_reply_type want;
   cell_reply_type got;

   function automatic int row_limit();
      return (rows_setting > MAX_ROWS) ? MAX_ROWS : rows_setting;
   endfunction

   function automatic int col_limit();
      return (cols_setting > MAX_COLS) ? MAX_COLS : cols_setting;
   endfunction

   function automatic void blank_canvas();
      int n;
      for (n = 0; n < MAX_ROWS*MAX_COLS; n++) begin
         canvas_image[n] = BLANK_CELL;
      end
   endfunction

   // One row of a shape, clipped to the active rows and columns.
   function automatic void paint_row_span(int row, int c0, int c1, logic [7:0] brush);
      int first;
      int last;
      int c;
      if (row < 0 || row >= row_limit()) return;
      first = (c0 < 0) ? 0 : c0;
      last = (c1 > col_limit() - 1) ? col_limit() - 1 : c1;
      for (c = first; c <= last; c++) begin
         canvas_image[row*MAX_COLS + c] = brush;
      end
   endfunction

   // Applies one command to the canvas image and returns the reply it gives.
   function automatic cell_reply_type predict_reply(logic [2:0] kind,
                                                    logic signed [7:0] anchor_col,
                                                    logic signed [7:0] anchor_row,
                                                    logic [6:0] span_wide,
                                                    logic [6:0] span_tall,
                                                    logic [7:0] brush,
                                                    logic [5:0] peek_row,
                                                    logic [5:0] peek_col);
      int x;
      int y;
      int w;
      int h;
      int i;
      int half;
      cell_reply_type r;
      x = anchor_col;
      y = anchor_row;
      w = span_wide;
      h = span_tall;
      r.cell_value = '0;
      r.cell_valid = 1'b0;
      case (kind)
         KIND_RECT: begin
            if (w > 0) begin
               for (i = 0; i < h; i++) paint_row_span(y + i, x, x + w - 1, brush);
            end
         end
         KIND_UP: begin
            for (i = 0; i < h; i++) paint_row_span(y + i, x - i, x + i, brush);
         end
         KIND_DOWN: begin
            for (i = 0; i < h; i++) paint_row_span(y - i, x - i, x + i, brush);
         end
         KIND_DIAMOND: begin
            for (i = -h; i <= h; i++) begin
               half = h - ((i < 0) ? -i : i);
               paint_row_span(y + i, x - half, x + half, brush);
            end
         end
         KIND_CLEAR: begin
            blank_canvas();
         end
         KIND_READ: begin
            if (int'(peek_row) < row_limit() && int'(peek_col) < col_limit()) begin
               r.cell_value = canvas_image[int'(peek_row)*MAX_COLS + int'(peek_col)];
               r.cell_valid = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         blank_canvas();
         rows_setting = ACTIVE_RESET;
         cols_setting = ACTIVE_RESET;
         expected_replies.delete();
         errors_seen = 0;
         checked_total = 0;
         hits_total = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ACTIVE_ROWS) begin
               rows_setting = int'(csr_data);
            end else if (csr_index == CSR_ACTIVE_COLS) begin
               cols_setting = int'(csr_data);
            end
         end
         // Results are taken before new items, so a stray result is never
         // paired with an item accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            got.cell_value = rsp_cell_value;
            got.cell_valid = rsp_cell_valid;
            if (expected_replies.size() == 0) begin
               errors_seen++;
               if (errors_seen <= 10) begin
                  $display("%0t: result with nothing outstanding: %02h %0b",
                           $realtime, got.cell_value, got.cell_valid);
               end
            end else begin
               want = expected_replies.pop_front();
               checked_total++;
               if (want.cell_valid) hits_total++;
               if (got.cell_value !== want.cell_value ||
                   got.cell_valid !== want.cell_valid) begin
                  errors_seen++;
                  if (errors_seen <= 10) begin
                     $display("%0t: result %0d: cell_value exp %02h got %02h,",
                              $realtime, checked_total, want.cell_value,
                              got.cell_value);
                     $display("   cell_valid exp %0b got %0b",
                              want.cell_valid, got.cell_valid);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_replies.push_back(predict_reply(req_kind, req_anchor_col, req_anchor_row,
                                                     req_span_wide, req_span_tall,
                                                     req_paint_char, req_peek_row,
                                                     req_peek_col));
         end
      end
      mismatch_count <= errors_seen;
      pending_replies <= expected_replies.size();
      replies_checked <= checked_total;
      active_reads <= hits_total;
   end

endmodule

### dv/tb_character_canvas_shape_filler.sv
`timescale 1ns / 1ps
// Top of the canvas fill engine testbench: clock, reset, stimulus and the verdict.
// Depends on ccsf_pkg, the engine top level and the canvas_fill_checker module.

// The stimulus runs in two parts. A short directed part paints and reads the
// corners of the canvas, the zero-size shapes, fully clipped shapes, the unused
// kinds and the size register extremes (zero, and values above the store size).
// The random part then walks through several size settings; in each one most
// shapes are small and anchored near the active area so that reads land on
// painted cells, with a few large or wildly placed shapes mixed in.
//
// All checking is done by the checker instance, which sees the same channels
// as the engine. This module only reads back its counters.

module tb_character_canvas_shape_filler;

   import ccsf_pkg::*;

   // Kinds that the engine must ignore apart from giving a blank reply.
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   // Highest register index, never mapped to a size register.
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_INDEX = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [2:0]             req_kind = KIND_RECT;
   logic signed [7:0]      req_anchor_col = '0;
   logic signed [7:0]      req_anchor_row = '0;
   logic [6:0]             req_span_wide = '0;
   logic [6:0]             req_span_tall = '0;
   logic [7:0]             req_paint_char = '0;
   logic [5:0]             req_peek_row = '0;
   logic [5:0]             req_peek_col = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_cell_value;
   logic                   rsp_cell_valid;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int mismatch_count;
   int pending_replies;
   int replies_checked;
   int active_reads;

   // When set, neither side idles; one whole random phase runs this way.
   logic no_idle = 1'b0;

   int items_sent = 0;
   int settings_used = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   character_canvas_shape_filler u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_anchor_col (req_anchor_col),
      .req_anchor_row (req_anchor_row),
      .req_span_wide  (req_span_wide),
      .req_span_tall  (req_span_tall),
      .req_paint_char (req_paint_char),
      .req_peek_row   (req_peek_row),
      .req_peek_col   (req_peek_col),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cell_valid (rsp_cell_valid),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   canvas_fill_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_anchor_col  (req_anchor_col),
      .req_anchor_row  (req_anchor_row),
      .req_span_wide   (req_span_wide),
      .req_span_tall   (req_span_tall),
      .req_paint_char  (req_paint_char),
      .req_peek_row    (req_peek_row),
      .req_peek_col    (req_peek_col),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_value  (rsp_cell_value),
      .rsp_cell_valid  (rsp_cell_valid),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .pending_replies (pending_replies),
      .replies_checked (replies_checked),
      .active_reads    (active_reads)
   );

   // Unless no_idle is set, the receiver stalls with a chance of about six in a hundred,
   // one fresh choice per clock, so stalls land on every stage of the engine's work.
   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 6);
   end

   // Offers one item and returns at the edge where it is taken. Valid is only
   // lowered when the sender decides to idle, so back-to-back items keep it high.
   task automatic send_cmd(input logic [2:0] kind, input logic [7:0] col,
                           input logic [7:0] row, input logic [6:0] wide,
                           input logic [6:0] tall, input logic [7:0] brush,
                           input logic [5:0] prow, input logic [5:0] pcol);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 6) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_anchor_col <= col;
      req_anchor_row <= row;
      req_span_wide <= wide;
      req_span_tall <= tall;
      req_paint_char <= brush;
      req_peek_row <= prow;
      req_peek_col <= pcol;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Holds the sender off until every outstanding result has been taken.
   // The checker's count is registered, which only makes the wait longer.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Writes both size registers and one unmapped index, which must be dropped.
   task automatic set_sizes(input int rows, input int cols,
                            input logic [CSR_INDEX_W-1:0] junk_index);
      write_csr(CSR_ACTIVE_ROWS, CSR_DATA_W'(rows));
      write_csr(CSR_ACTIVE_COLS, CSR_DATA_W'(cols));
      write_csr(junk_index, CSR_DATA_W'($urandom()));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [CSR_INDEX_W-1:0] unmapped_index();
      return CSR_INDEX_W'($urandom_range(int'(CSR_ACTIVE_COLS) + 1, int'(CSR_LAST_INDEX)));
   endfunction

   // One random item for an active area of rows_lim by cols_lim cells (already
   // clamped to the store). Paints and reads dominate; clears are rare since each
   // one sweeps the whole store.
   task automatic random_cmd(input int rows_lim, input int cols_lim);
      int pick;
      logic [2:0] kind;
      logic [7:0] col;
      logic [7:0] row;
      logic [6:0] wide;
      logic [6:0] tall;
      logic [5:0] prow;
      logic [5:0] pcol;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         kind = 3'($urandom_range(int'(KIND_RECT), int'(KIND_DIAMOND)));
      end else if (pick < 90) begin
         kind = KIND_READ;
      end else if (pick < 93) begin
         kind = KIND_CLEAR;
      end else begin
         kind = pick[0] ? KIND_SPARE_HI : KIND_SPARE_LO;
      end
      // Anchors mostly straddle the active area so that clipping is exercised on
      // every edge; the rest cover the whole signed range.
      if ($urandom_range(0, 99) < 85) col = 8'($urandom_range(0, cols_lim + 15) - 8);
      else col = 8'($urandom());
      if ($urandom_range(0, 99) < 85) row = 8'($urandom_range(0, rows_lim + 15) - 8);
      else row = 8'($urandom());
      // Large spans are rare, since a big shape is slow to paint.
      if ($urandom_range(0, 9) != 0) wide = 7'($urandom_range(0, 12));
      else wide = 7'($urandom());
      if ($urandom_range(0, 9) != 0) tall = 7'($urandom_range(0, 12));
      else tall = 7'($urandom());
      if (rows_lim > 0 && $urandom_range(0, 99) < 85) prow = 6'($urandom_range(0, rows_lim - 1));
      else prow = 6'($urandom());
      if (cols_lim > 0 && $urandom_range(0, 99) < 85) pcol = 6'($urandom_range(0, cols_lim - 1));
      else pcol = 6'($urandom());
      send_cmd(kind, col, row, wide, tall, 8'($urandom()), prow, pcol);
   endtask

   function automatic int clamp_rows(input int v);
      return (v > DEFAULT_MAX_ROWS) ? DEFAULT_MAX_ROWS : v;
   endfunction

   function automatic int clamp_cols(input int v);
      return (v > DEFAULT_MAX_COLS) ? DEFAULT_MAX_COLS : v;
   endfunction

   initial begin
      int phase_rows [8];
      int phase_cols [8];
      int p;
      int n;
      int burst;
      phase_rows = '{64, 16, 1, 64, 3, 127, 0, 0};
      phase_cols = '{64, 16, 1, 7, 64, 100, 37, 0};
      phase_rows[7] = $urandom_range(1, 64);
      phase_cols[7] = $urandom_range(1, 64);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The engine is still sweeping its store after reset; size writes are
      // taken meanwhile and the first item simply waits for req_ready.
      set_sizes(64, 64, CSR_LAST_INDEX);

      // Reads of untouched corners see the blank cell.
      send_cmd(KIND_READ, 8'd0, 8'd0, 7'd0, 7'd0, 8'h00, 6'd0, 6'd0);
      send_cmd(KIND_READ, 8'hFF, 8'hFF, 7'h7F, 7'h7F, 8'hFF, 6'd63, 6'd63);
      // Shapes that lie wholly outside the canvas paint nothing.
      send_cmd(KIND_RECT, 8'h80, 8'h80, 7'h7F, 7'h7F, 8'hFF, 6'd0, 6'd0);
      send_cmd(KIND_RECT, 8'h7F, 8'h7F, 7'h7F, 7'h7F, 8'h00, 6'd0, 6'd0);
      // A rectangle hanging off the top left corner keeps its visible part.
      send_cmd(KIND_RECT, 8'hFD, 8'hFE, 7'd10, 7'd6, "A", 6'd0, 6'd0);
      // Zero width and zero height paint nothing; the other two triangles clip at an edge.
      send_cmd(KIND_RECT, 8'd30, 8'd30, 7'd0, 7'd5, "Z", 6'd0, 6'd0);
      send_cmd(KIND_RECT, 8'd30, 8'd30, 7'd20, 7'd0, "Z", 6'd0, 6'd0);
      send_cmd(KIND_UP, 8'd5, 8'd60, 7'd0, 7'd10, "U", 6'd0, 6'd0);
      send_cmd(KIND_UP, 8'd40, 8'd40, 7'd0, 7'd0, "u", 6'd0, 6'd0);
      send_cmd(KIND_DOWN, 8'd62, 8'd5, 7'd0, 7'd9, "D", 6'd0, 6'd0);
      // A diamond of radius zero paints its centre cell only.
      send_cmd(KIND_DIAMOND, 8'd20, 8'd20, 7'd0, 7'd0, "*", 6'd0, 6'd0);
      send_cmd(KIND_DIAMOND, 8'd0, 8'd63, 7'd0, 7'd5, "o", 6'd0, 6'd0);
      send_cmd(KIND_READ, 8'd0, 8'd0, 7'd0, 7'd0, 8'h00, 6'd20, 6'd20);
      send_cmd(KIND_READ, 8'd0, 8'd0, 7'd0, 7'd0, 8'h00, 6'd0, 6'd0);
      send_cmd(KIND_READ, 8'd0, 8'd0, 7'd0, 7'd0, 8'h00, 6'd5, 6'd62);
      // Unused kinds change nothing.
      send_cmd(KIND_SPARE_LO, 8'd10, 8'd10, 7'd5, 7'd5, "X", 6'd20, 6'd20);
      send_cmd(KIND_SPARE_HI, 8'd10, 8'd10, 7'd5, 7'd5, "Y", 6'd0, 6'd0);
      // The largest diamond covers the whole canvas; a clear then wipes it.
      send_cmd(KIND_DIAMOND, 8'd32, 8'd32, 7'd0, 7'h7F, 8'h80, 6'd0, 6'd0);
      send_cmd(KIND_READ, 8'd0, 8'd0, 7'd0, 7'd0, 8'h00, 6'd63, 6'd0);
      send_cmd(KIND_CLEAR, 8'd0, 8'd0, 7'd0, 7'd0, 8'h00, 6'd0, 6'd0);
      send_cmd(KIND_READ, 8'd0, 8'd0, 7'd0, 7'd0, 8'h00, 6'd63, 6'd0);

      // With no active cell nothing paints and every read is invalid.
      drain();
      set_sizes(0, 0, unmapped_index());
      send_cmd(KIND_RECT, 8'd0, 8'd0, 7'd64, 7'd64, "#", 6'd0, 6'd0);
      send_cmd(KIND_READ, 8'd0, 8'd0, 7'd0, 7'd0, 8'h00, 6'd0, 6'd0);

      // Sizes above the store act as the store size.
      drain();
      set_sizes(127, 127, unmapped_index());
      send_cmd(KIND_RECT, 8'd60, 8'd60, 7'h7F, 7'h7F, "%", 6'd0, 6'd0);
      send_cmd(KIND_READ, 8'd0, 8'd0, 7'd0, 7'd0, 8'h00, 6'd63, 6'd63);

      // Reads at and just inside a small active limit.
      drain();
      set_sizes(5, 9, unmapped_index());
      send_cmd(KIND_READ, 8'd0, 8'd0, 7'd0, 7'd0, 8'h00, 6'd5, 6'd0);
      send_cmd(KIND_READ, 8'd0, 8'd0, 7'd0, 7'd0, 8'h00, 6'd4, 6'd8);

      // Random phases, each under its own size setting. The second phase runs
      // with no idling on either side.
      for (p = 0; p < 8; p++) begin
         drain();
         no_idle <= (p == 1);
         set_sizes(phase_rows[p], phase_cols[p], unmapped_index());
         burst = (phase_rows[p] == 0) ? 30 : 124;
         for (n = 0; n < burst; n++) begin
            // Now and then the sender waits for the engine to empty completely.
            if ($urandom_range(0, 99) == 0) drain();
            random_cmd(clamp_rows(phase_rows[p]), clamp_cols(phase_cols[p]));
         end
      end

      drain();
      // Leave room for any stray result after the last expected one.
      repeat (64) @(posedge clock);

      $display("covered %0d items under %0d size settings, including clears and clipped shapes",
               items_sent, settings_used);
      $display("%0d results compared, %0d of them reads of active cells",
               replies_checked, active_reads);
      if (mismatch_count == 0 && pending_replies == 0) begin
         $display("character_canvas_shape_filler regression: pass");
      end else begin
         $display("character_canvas_shape_filler regression: fail");
      end
      $finish;
   end

   // A correct run needs well under a quarter of this even with every item at
   // its worst; reaching it means the engine has hung.
   initial begin
      #200_000_000;
      $display("character_canvas_shape_filler regression: fail");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/ccsf_pkg.sv
rtl/ccsf_ctrl.sv
rtl/ccsf_datapath.sv
rtl/character_canvas_shape_filler.sv
rtl/ccsf_checker.sv
dv/canvas_fill_checker.sv
dv/tb_character_canvas_shape_filler.sv
